// ===== rtl/core/pcps_pkg.sv =====
// Package for the PCM channel peak statistics block.
// Holds shared constants, types and the CRC-32 step function; no dependencies.
`default_nettype none
package pcps_pkg;
	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_COUNTER_BITS = 48;
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_IDX_BITS = 4;
	localparam int CFG_DATA_BITS = 4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CRC_ENABLE = 4'd1;
	localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd2;
	localparam logic [15:0] CLIP_POS = 16'h7fff;
	localparam logic [15:0] CLIP_NEG = 16'h8000;
	localparam logic [31:0] CRC_POLY = 32'hedb88320;

	typedef enum logic {
		MODE_FRAME = 1'b0,
		MODE_REPORT = 1'b1
	} mode_t;

	// One 16-bit sample, low byte first, through the reflected CRC-32.
	function automatic logic [31:0] crc_sample(input logic [31:0] crc, input logic [15:0] raw);
		logic [31:0] c;
		c = ~crc;
		for (int i = 0; i < 16; i++) begin
			c = c ^ {31'd0, raw[i]};
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pcps_lane.sv =====
// One channel lane: peak, absolute sum, clip count and CRC accumulators.
// Depends on pcps_pkg.
`default_nettype none
module pcps_lane
	import pcps_pkg::*;
#(
	parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic update,
	input wire logic crc_on,
	input wire logic [15:0] sample,
	output logic [15:0] peak,
	output logic [COUNTER_BITS-1:0] sum,
	output logic [COUNTER_BITS-1:0] clips,
	output logic [31:0] crc
);
	localparam logic [COUNTER_BITS-1:0] LIMIT = '1;
	logic [15:0] mag;
	logic [COUNTER_BITS:0] sum_wide;
	logic is_clip;

	// Magnitude of the sample; -32768 gives 32768.
	assign mag = sample[15] ? (16'd0 - sample) : sample;
	assign is_clip = (sample == CLIP_POS) || (sample == CLIP_NEG);
	assign sum_wide = {1'b0, sum} + {{(COUNTER_BITS-15){1'b0}}, mag};

	// Accumulators update on each accepted frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak <= '0;
			sum <= '0;
			clips <= '0;
			crc <= '0;
		end else if (update) begin
			if (mag > peak) peak <= mag;
			sum <= sum_wide[COUNTER_BITS] ? LIMIT : sum_wide[COUNTER_BITS-1:0];
			if (is_clip && clips != LIMIT) clips <= clips + 1'b1;
			if (crc_on) crc <= crc_sample(crc, sample);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/pcps_report.sv =====
// Back part: walks the active channels of a report and fills a two-entry output queue.
// Depends on pcps_pkg.
`default_nettype none
module pcps_report
	import pcps_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int COUNTER_BITS = DEF_COUNTER_BITS,
	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [3:0] n_active,
	input wire logic [MAX_CHANNELS-1:0][15:0] peak,
	input wire logic [MAX_CHANNELS-1:0][COUNTER_BITS-1:0] sum,
	input wire logic [MAX_CHANNELS-1:0][COUNTER_BITS-1:0] clips,
	input wire logic [MAX_CHANNELS-1:0][31:0] crc,
	input wire logic [COUNTER_BITS-1:0] frames,
	output logic busy,
	output logic empty,
	input wire logic pop,
	output logic [2:0] channel_index,
	output logic [15:0] peak_level,
	output logic [47:0] abs_sum,
	output logic [47:0] clipped_count,
	output logic [31:0] crc_value,
	output logic [47:0] frame_total,
	output logic last_line
);
	typedef struct packed {
		logic [2:0] idx;
		logic [15:0] peak;
		logic [47:0] sum;
		logic [47:0] clips;
		logic [31:0] crc;
		logic [47:0] frames;
		logic last;
	} line_t;

	logic active_q;
	logic [CW-1:0] ch_q;
	logic [3:0] last_q;
	line_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push_line, pop_line, fin;
	line_t line;

	assign busy = active_q;
	assign empty = (cnt_q == 2'd0);
	assign pop_line = pop && !empty;
	assign push_line = active_q && (cnt_q != 2'd2 || pop_line);
	assign fin = ({{(4-CW){1'b0}}, ch_q} == last_q);

	// Build the line of the current channel.
	always_comb begin
		line.idx = 3'({{(4-CW){1'b0}}, ch_q});
		line.peak = peak[ch_q];
		line.sum = 48'({{(64-COUNTER_BITS){1'b0}}, sum[ch_q]});
		line.clips = 48'({{(64-COUNTER_BITS){1'b0}}, clips[ch_q]});
		line.crc = crc[ch_q];
		line.frames = 48'({{(64-COUNTER_BITS){1'b0}}, frames});
		line.last = fin;
	end

	// Channel walk and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ch_q <= '0;
			last_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				ch_q <= '0;
				last_q <= n_active - 4'd1;
			end else if (push_line) begin
				ch_q <= ch_q + 1'b1;
				if (fin) active_q <= 1'b0;
			end
			if (push_line) wr_q <= ~wr_q;
			if (pop_line) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push_line} - {1'b0, pop_line};
		end
	end

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push_line) buf_q[wr_q] <= line;
	end

	assign channel_index = buf_q[rd_q].idx;
	assign peak_level = buf_q[rd_q].peak;
	assign abs_sum = buf_q[rd_q].sum;
	assign clipped_count = buf_q[rd_q].clips;
	assign crc_value = buf_q[rd_q].crc;
	assign frame_total = buf_q[rd_q].frames;
	assign last_line = buf_q[rd_q].last;
endmodule
`default_nettype wire

// ===== rtl/core/pcm_channel_peak_stats_top.sv =====
// Top level of the PCM channel peak statistics block.
// Depends on pcps_pkg, pcps_lane and pcps_report.
//
// A sample frame updates every active lane in the cycle it is accepted, so frames
// stream at one item per clock. During a report the back part walks the active
// channels and writes one line per clock into a two-entry output queue while the
// queue has room; new items wait (full high) only while a report walk is running.
`default_nettype none
module pcm_channel_peak_stats_top
	import pcps_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic mode,
	input wire logic signed [15:0] sample_0,
	input wire logic signed [15:0] sample_1,
	input wire logic signed [15:0] sample_2,
	input wire logic signed [15:0] sample_3,
	input wire logic signed [15:0] sample_4,
	input wire logic signed [15:0] sample_5,
	input wire logic signed [15:0] sample_6,
	input wire logic signed [15:0] sample_7,
	output logic empty,
	input wire logic pop,
	output logic [2:0] channel_index,
	output logic [15:0] peak_level,
	output logic [47:0] abs_sum,
	output logic [47:0] clipped_count,
	output logic [31:0] crc_value,
	output logic [47:0] frame_total,
	output logic last_line,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input wire logic [CFG_DATA_BITS-1:0] cfg_data
);
	localparam logic [COUNTER_BITS-1:0] LIMIT = '1;
	logic [3:0] chan_q;
	logic crc_en_q;
	logic [COUNTER_BITS-1:0] frames_q;
	logic [3:0] n_active;
	logic accept, busy;
	logic [7:0][15:0] samples;
	logic [MAX_CHANNELS-1:0][15:0] peak;
	logic [MAX_CHANNELS-1:0][COUNTER_BITS-1:0] sum, clips;
	logic [MAX_CHANNELS-1:0][31:0] crc;

	assign cfg_ready = 1'b1;
	assign full = busy;
	assign accept = push && !full;
	assign samples = {sample_7, sample_6, sample_5, sample_4,
		sample_3, sample_2, sample_1, sample_0};

	// Clamp the channel count to 1..MAX_CHANNELS.
	always_comb begin
		if (chan_q == 4'd0) n_active = 4'd1;
		else if (chan_q > 4'(MAX_CHANNELS)) n_active = 4'(MAX_CHANNELS);
		else n_active = chan_q;
	end

	// Configuration registers and frame counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHANNEL_COUNT_RESET;
			crc_en_q <= 1'b0;
			frames_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == REG_CHANNEL_COUNT) chan_q <= cfg_data[3:0];
			if (cfg_valid && cfg_index == REG_CRC_ENABLE) crc_en_q <= cfg_data[0];
			if (accept && mode == MODE_FRAME && frames_q != LIMIT) frames_q <= frames_q + 1'b1;
		end
	end

	// Front part: one accumulator lane per channel.
	for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
		pcps_lane #(.COUNTER_BITS(COUNTER_BITS)) u_lane (
			.clk(clk), .arst_n(arst_n),
			.update(accept && mode == MODE_FRAME && 4'(g) < n_active),
			.crc_on(crc_en_q), .sample(samples[g]),
			.peak(peak[g]), .sum(sum[g]), .clips(clips[g]), .crc(crc[g])
		);
	end

	// Back part: report lines into the output queue.
	pcps_report #(.MAX_CHANNELS(MAX_CHANNELS), .COUNTER_BITS(COUNTER_BITS)) u_report (
		.clk(clk), .arst_n(arst_n),
		.start(accept && mode == MODE_REPORT), .n_active(n_active),
		.peak(peak), .sum(sum), .clips(clips), .crc(crc), .frames(frames_q),
		.busy(busy), .empty(empty), .pop(pop),
		.channel_index(channel_index), .peak_level(peak_level), .abs_sum(abs_sum),
		.clipped_count(clipped_count), .crc_value(crc_value),
		.frame_total(frame_total), .last_line(last_line)
	);
endmodule
`default_nettype wire
